// ===== rtl/rgb_serpentine_error_diffusion_dither_core_macros.svh =====
// ----------------------------------------------------------------------------
// rgb_serpentine_error_diffusion_dither_core_macros
// Assertion helpers shared by the dither core.
// ----------------------------------------------------------------------------
`ifndef RGB_SERPENTINE_ERROR_DIFFUSION_DITHER_CORE_MACROS_SVH
`define RGB_SERPENTINE_ERROR_DIFFUSION_DITHER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSED_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rsed: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RSED_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rsed: next-cycle check failed");

`endif

// ===== rtl/rsed_pkg.sv =====
// ----------------------------------------------------------------------------
// rsed_pkg
// Types and constants shared by the serpentine error diffusion dither core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsed_pkg;

    // field widths
    localparam int PIX_W     = 8;
    localparam int LVL_W     = 8;
    localparam int WGT_W     = 16;
    localparam int IDX_W     = 32;
    localparam int COL_W     = 11;
    localparam int RW_W      = 12;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LANES     = 3;

    // error arithmetic
    localparam int ERR_W   = 16;
    localparam int TAG_W   = 16;
    localparam int QSTEP_B = 10;              // quantization step of 1024
    localparam int DIV_SH  = 4;               // shares are sixteenths
    localparam int MUL_W   = QSTEP_B + 4;
    localparam int SHARE_W = MUL_W - DIV_SH;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_ROW_WIDTH   = 3'd0;
    localparam cfg_idx_t REG_RED_LMAX    = 3'd1;
    localparam cfg_idx_t REG_GREEN_LMAX  = 3'd2;
    localparam cfg_idx_t REG_BLUE_LMAX   = 3'd3;
    localparam cfg_idx_t REG_RED_WGT     = 3'd4;
    localparam cfg_idx_t REG_GREEN_WGT   = 3'd5;
    localparam cfg_idx_t REG_BLUE_WGT    = 3'd6;
    localparam cfg_idx_t REG_PIXEL_BASE  = 3'd7;

    // register reset values
    localparam logic [RW_W-1:0]  RST_ROW_WIDTH  = 12'd640;
    localparam logic [LVL_W-1:0] RST_LMAX       = 8'd4;
    localparam logic [WGT_W-1:0] RST_RED_WGT    = 16'd25;
    localparam logic [WGT_W-1:0] RST_GREEN_WGT  = 16'd5;
    localparam logic [WGT_W-1:0] RST_BLUE_WGT   = 16'd1;
    localparam logic [IDX_W-1:0] RST_PIXEL_BASE = 32'd0;

    typedef logic signed [ERR_W-1:0] err_t;

    // one error buffer entry: epoch tag plus one error per channel
    typedef struct packed {
        logic [TAG_W-1:0]              tag;
        logic [LANES-1:0][ERR_W-1:0]   err;
    } err_word_t;

    // what one channel lane produces
    typedef struct packed {
        logic [LVL_W-1:0]          part;
        logic signed [SHARE_W-1:0] s7;
        logic signed [SHARE_W-1:0] s3;
        logic signed [SHARE_W-1:0] s5;
        logic signed [SHARE_W-1:0] s1;
    } lane_out_t;

    // merge stage strobes
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } merge_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUANT,
        S_SPREAD0,
        S_SPREAD1,
        S_SPREAD2
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rsed_if.sv =====
// ----------------------------------------------------------------------------
// rsed_if
// Valid/ready channels for pixel words in and index words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsed_pix_if import rsed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             start_of_image;

    modport source (output valid, red_in, green_in, blue_in, start_of_image, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, start_of_image, output ready);
endinterface

interface rsed_res_if import rsed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_index;
    logic [COL_W-1:0] column;
    logic             row_done;

    modport source (output valid, pixel_index, column, row_done, input ready);
    modport sink   (input valid, pixel_index, column, row_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/rsed_err_ram.sv =====
// ----------------------------------------------------------------------------
// rsed_err_ram
// One-write one-read error row memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsed_err_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsed_lane.sv =====
// ----------------------------------------------------------------------------
// rsed_lane
// One color channel: scale, add carried error, round to a level, split residue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsed_lane import rsed_pkg::*; (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [PIX_W-1:0] pix,
    input  wire logic [LVL_W-1:0] lmax,
    input  wire err_t             err,
    output lane_out_t             q
);
    localparam int PROD_W = PIX_W + LVL_W;
    localparam int V_W    = PROD_W + 4;
    localparam int Q_W    = V_W - QSTEP_B;

    logic [PROD_W-1:0]        prod;
    logic signed [V_W-1:0]    v;
    logic [QSTEP_B-1:0]       low;
    logic [Q_W-1:0]           quo_rnd;
    logic                     fneg;
    logic signed [QSTEP_B:0]  frac;
    logic signed [MUL_W-1:0]  fx;
    lane_out_t                q_next;

    // truncating divide by sixteen
    function automatic logic signed [SHARE_W-1:0] div16(input logic signed [MUL_W-1:0] m);
        logic signed [MUL_W-1:0] t;
        t = m + (m[MUL_W-1] ? MUL_W'((1 << DIV_SH) - 1) : MUL_W'(0));
        return SHARE_W'(t >>> DIV_SH);
    endfunction

    // quantize and split residue
    always_comb
    begin
        prod    = PROD_W'(pix) * PROD_W'(lmax);
        v       = $signed({2'b00, prod, 2'b00}) + V_W'(err);
        low     = v[QSTEP_B-1:0];
        quo_rnd = v[V_W-1:QSTEP_B] + Q_W'(low[QSTEP_B-1]);
        fneg    = v[V_W-1] ? (low != '0) : low[QSTEP_B-1];
        frac    = $signed({fneg, low});
        fx      = MUL_W'(frac);
        if (v[V_W-1])
        begin
            q_next.part = '0;
        end
        else if (quo_rnd > Q_W'(lmax))
        begin
            q_next.part = lmax;
        end
        else
        begin
            q_next.part = LVL_W'(quo_rnd);
        end
        q_next.s7 = div16((fx <<< 3) - fx);
        q_next.s3 = div16((fx <<< 1) + fx);
        q_next.s5 = div16((fx <<< 2) + fx);
        q_next.s1 = div16(fx);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q <= q_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsed_merge.sv =====
// ----------------------------------------------------------------------------
// rsed_merge
// Combines the lane levels into a colormap index: base plus weighted levels.
// ----------------------------------------------------------------------------
`default_nettype none

module rsed_merge import rsed_pkg::*; (
    input  wire logic             clk,
    input  wire merge_ctl_t       ctl,
    input  wire logic [LVL_W-1:0] part   [LANES],
    input  wire logic [WGT_W-1:0] weight [LANES],
    input  wire logic [IDX_W-1:0] base,
    output logic      [IDX_W-1:0] index
);
    localparam int P_W = LVL_W + WGT_W;

    logic [P_W-1:0]   prod_reg [LANES];
    logic [IDX_W-1:0] sum_next;
    logic [IDX_W-1:0] sum_reg;

    // per-lane products
    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                prod_reg[i] <= P_W'(part[i]) * P_W'(weight[i]);
            end
        end
    end

    // sum modulo 2^32
    always_comb
    begin
        sum_next = base;
        for (int i = 0; i < LANES; i++)
        begin
            sum_next = sum_next + IDX_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign index = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/rgb_serpentine_error_diffusion_dither_core.sv =====
// ----------------------------------------------------------------------------
// rgb_serpentine_error_diffusion_dither_core
// Serpentine Floyd-Steinberg dither of RGB pixels into a colormap index.
// ----------------------------------------------------------------------------
// Usage:
//  pixels: one RGB word per pixel in serpentine order, start_of_image on the
//    first pixel of a frame clears both error rows and restarts at row zero.
//  results: one word per pixel with pixel_index, column and row_done.
//  cfg: write enable, register index and data; user writes only while idle (not enforced).
// Sequence: a pixel occupies the core through S_QUANT, S_SPREAD0, S_SPREAD1
//  and S_SPREAD2, since the error row memories have one write port each; its
//  result word is loaded in S_SPREAD2 and the next pixel is taken back in S_IDLE.
//  The result sits in an output register, so a stalled receiver holds one word
//  while the next pixel runs; the block stops only when a second result is
//  ready and the first is held.
// Reset: registers return to their defaults, then both error rows are
//  cleared, one entry per cycle, through all MAX_WIDTH+2 entries (2050 by default);
//  pixels.ready stays low meanwhile, configuration writes are still taken.
// Three lanes quantize red, green and blue side by side, a merge stage
// forms the weighted index. Error rows carry an epoch tag per entry, so
// row starts need no clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_serpentine_error_diffusion_dither_core_macros.svh"

module rgb_serpentine_error_diffusion_dither_core import rsed_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    rsed_pix_if.sink                  pixels,
    rsed_res_if.source                results
);
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SLOTS = MAX_WIDTH + 2;
    localparam int SW    = $clog2(SLOTS);
    localparam int XW    = (CW + 1 > RW_W) ? CW + 1 : RW_W;

    // configuration registers
    logic [RW_W-1:0]  row_width_reg;
    logic [LVL_W-1:0] lmax_reg   [LANES];
    logic [WGT_W-1:0] weight_reg [LANES];
    logic [IDX_W-1:0] base_reg;

    // frame position
    logic [CW-1:0]    column_count_reg;
    logic             reverse_reg;
    logic             swap_reg;
    logic [TAG_W-1:0] epoch_reg;
    logic [TAG_W-1:0] ep_reg [2];

    // reset clearing sweep
    logic             clearing_reg;
    logic [SW-1:0]    clr_reg;

    // per-pixel context
    state_t           state_reg;
    state_t           state_next;
    logic [CW-1:0]    col_reg;
    logic             rev_reg;
    logic             done_reg;
    logic             cur_reg;
    logic [PIX_W-1:0] pix_reg [LANES];
    err_word_t        hold_a_reg;
    err_word_t        hold_b_reg;

    // output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_done_reg;

    logic             accept;
    logic             out_load;
    logic             sof;
    logic [CW-1:0]    cc;
    logic             rv;
    logic             sw;
    logic [XW-1:0]    rw_x;
    logic [XW-1:0]    w_x;
    logic [CW-1:0]    last;
    logic [CW-1:0]    pos;
    logic [CW-1:0]    col;
    logic             done;

    logic [SW-1:0]    s0;
    logic [SW-1:0]    s1;
    logic [SW-1:0]    s2;
    logic [SW-1:0]    carry;
    logic             cur_sel;

    logic             cur_re;
    logic             nxt_re;
    logic             cur_we;
    logic             nxt_we;
    logic [SW-1:0]    cur_raddr;
    logic [SW-1:0]    nxt_raddr;
    logic [SW-1:0]    cur_waddr;
    logic [SW-1:0]    nxt_waddr;
    err_word_t        cur_wdata;
    err_word_t        nxt_wdata;
    err_word_t        cur_rd;
    err_word_t        nxt_rd;

    logic             bank_we    [2];
    logic             bank_re    [2];
    logic [SW-1:0]    bank_waddr [2];
    logic [SW-1:0]    bank_raddr [2];
    err_word_t        bank_wdata [2];
    err_word_t        bank_rdata [2];

    lane_out_t        lane_q    [LANES];
    logic [LVL_W-1:0] lane_part [LANES];
    merge_ctl_t       merge_ctl;
    logic [IDX_W-1:0] merge_index;

    // entry not written since its row was cleared reads as zero
    function automatic err_word_t mask_word(input err_word_t w, input logic [TAG_W-1:0] ep);
        err_word_t r;
        r = w;
        if (w.tag != ep)
        begin
            r.err = '0;
        end
        return r;
    endfunction

    // handshakes
    assign pixels.ready = (state_reg == S_IDLE) && !clearing_reg;
    assign accept       = pixels.valid && pixels.ready;
    assign out_load     = (state_reg == S_SPREAD2) && (!out_valid_reg || results.ready);

    // row width, direction and column of the offered pixel
    always_comb
    begin
        sof  = pixels.start_of_image;
        cc   = sof ? '0 : column_count_reg;
        rv   = sof ? 1'b0 : reverse_reg;
        sw   = sof ? 1'b0 : swap_reg;
        rw_x = XW'(row_width_reg);
        if (rw_x == '0)
        begin
            w_x = XW'(1);
        end
        else if (rw_x > XW'(MAX_WIDTH))
        begin
            w_x = XW'(MAX_WIDTH);
        end
        else
        begin
            w_x = rw_x;
        end
        last = CW'(w_x - XW'(1));
        pos  = (cc < last) ? cc : last;
        col  = rv ? last - pos : pos;
        done = (cc >= last);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= RST_ROW_WIDTH;
            lmax_reg[0]   <= RST_LMAX;
            lmax_reg[1]   <= RST_LMAX;
            lmax_reg[2]   <= RST_LMAX;
            weight_reg[0] <= RST_RED_WGT;
            weight_reg[1] <= RST_GREEN_WGT;
            weight_reg[2] <= RST_BLUE_WGT;
            base_reg      <= RST_PIXEL_BASE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:  row_width_reg <= cfg_data[RW_W-1:0];
                REG_RED_LMAX:   lmax_reg[0]   <= cfg_data[LVL_W-1:0];
                REG_GREEN_LMAX: lmax_reg[1]   <= cfg_data[LVL_W-1:0];
                REG_BLUE_LMAX:  lmax_reg[2]   <= cfg_data[LVL_W-1:0];
                REG_RED_WGT:    weight_reg[0] <= cfg_data[WGT_W-1:0];
                REG_GREEN_WGT:  weight_reg[1] <= cfg_data[WGT_W-1:0];
                REG_BLUE_WGT:   weight_reg[2] <= cfg_data[WGT_W-1:0];
                REG_PIXEL_BASE: base_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // frame position and row epochs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            reverse_reg      <= 1'b0;
            swap_reg         <= 1'b0;
            epoch_reg        <= '0;
            ep_reg[0]        <= '0;
            ep_reg[1]        <= '0;
        end
        else if (accept)
        begin
            column_count_reg <= done ? '0 : cc + CW'(1);
            reverse_reg      <= done ? ~rv : rv;
            swap_reg         <= done ? ~sw : sw;
            if (sof)
            begin
                epoch_reg <= epoch_reg + TAG_W'(2);
                ep_reg[0] <= epoch_reg + TAG_W'(1);
                ep_reg[1] <= epoch_reg + TAG_W'(2);
            end
            else if (cc == '0)
            begin
                epoch_reg   <= epoch_reg + TAG_W'(1);
                ep_reg[~sw] <= epoch_reg + TAG_W'(1);
            end
        end
    end

    // clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_reg + SW'(1);
            if (clr_reg == SW'(SLOTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    state_next = accept ? S_QUANT : S_IDLE;
            S_QUANT:   state_next = S_SPREAD0;
            S_SPREAD0: state_next = S_SPREAD1;
            S_SPREAD1: state_next = S_SPREAD2;
            S_SPREAD2: state_next = out_load ? S_IDLE : S_SPREAD2;
            default:   state_next = S_IDLE;
        endcase
    end

    // pixel context
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg    <= col;
            rev_reg    <= rv;
            done_reg   <= done;
            cur_reg    <= sw;
            pix_reg[0] <= pixels.red_in;
            pix_reg[1] <= pixels.green_in;
            pix_reg[2] <= pixels.blue_in;
        end
        if (state_reg == S_QUANT)
        begin
            hold_a_reg <= nxt_rd;
        end
        if (state_reg == S_SPREAD0)
        begin
            hold_b_reg <= nxt_rd;
        end
    end

    // slot addresses, entry c+1 belongs to column c
    assign s0    = SW'(col_reg);
    assign s1    = s0 + SW'(1);
    assign s2    = s0 + SW'(2);
    assign carry = rev_reg ? s0 : s2;

    assign cur_sel = (state_reg == S_IDLE) ? sw : cur_reg;
    assign cur_rd  = mask_word(bank_rdata[cur_sel], ep_reg[cur_sel]);
    assign nxt_rd  = mask_word(bank_rdata[~cur_sel], ep_reg[~cur_sel]);

    // memory sequencing per state
    always_comb
    begin
        cur_re        = 1'b0;
        nxt_re        = 1'b0;
        cur_we        = 1'b0;
        nxt_we        = 1'b0;
        cur_raddr     = s1;
        nxt_raddr     = s0;
        cur_waddr     = carry;
        nxt_waddr     = s0;
        cur_wdata     = cur_rd;
        nxt_wdata     = hold_a_reg;
        cur_wdata.tag = ep_reg[cur_sel];
        nxt_wdata.tag = ep_reg[~cur_sel];
        merge_ctl     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cur_re    = accept;
                nxt_re    = accept;
                cur_raddr = SW'(col) + SW'(1);
                nxt_raddr = SW'(col);
            end
            S_QUANT:
            begin
                cur_re    = 1'b1;
                nxt_re    = 1'b1;
                cur_raddr = carry;
                nxt_raddr = s1;
            end
            S_SPREAD0:
            begin
                nxt_re            = 1'b1;
                nxt_raddr         = s2;
                cur_we            = 1'b1;
                nxt_we            = 1'b1;
                merge_ctl.prod_en = 1'b1;
                for (int i = 0; i < LANES; i++)
                begin
                    cur_wdata.err[i] = cur_rd.err[i] + ERR_W'(lane_q[i].s7);
                    nxt_wdata.err[i] = hold_a_reg.err[i]
                                     + ERR_W'(rev_reg ? lane_q[i].s1 : lane_q[i].s3);
                end
            end
            S_SPREAD1:
            begin
                nxt_we           = 1'b1;
                nxt_waddr        = s1;
                merge_ctl.sum_en = 1'b1;
                for (int i = 0; i < LANES; i++)
                begin
                    nxt_wdata.err[i] = hold_b_reg.err[i] + ERR_W'(lane_q[i].s5);
                end
            end
            S_SPREAD2:
            begin
                nxt_we    = out_load;
                nxt_waddr = s2;
                for (int i = 0; i < LANES; i++)
                begin
                    nxt_wdata.err[i] = nxt_rd.err[i]
                                     + ERR_W'(rev_reg ? lane_q[i].s3 : lane_q[i].s1);
                end
            end
            default: ;
        endcase
    end

    // map current and next roles onto the two banks
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            if (clearing_reg)
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = clr_reg;
                bank_wdata[b] = '0;
                bank_re[b]    = 1'b0;
                bank_raddr[b] = clr_reg;
            end
            else if (cur_sel == 1'(b))
            begin
                bank_we[b]    = cur_we;
                bank_waddr[b] = cur_waddr;
                bank_wdata[b] = cur_wdata;
                bank_re[b]    = cur_re;
                bank_raddr[b] = cur_raddr;
            end
            else
            begin
                bank_we[b]    = nxt_we;
                bank_waddr[b] = nxt_waddr;
                bank_wdata[b] = nxt_wdata;
                bank_re[b]    = nxt_re;
                bank_raddr[b] = nxt_raddr;
            end
        end
    end

    // error row banks
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        rsed_err_ram #(
            .DEPTH (SLOTS),
            .WIDTH ($bits(err_word_t))
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr[b]),
            .wdata (bank_wdata[b]),
            .re    (bank_re[b]),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    // channel lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        rsed_lane u_lane (
            .clk  (clk),
            .en   (state_reg == S_QUANT),
            .pix  (pix_reg[i]),
            .lmax (lmax_reg[i]),
            .err  (err_t'(cur_rd.err[i])),
            .q    (lane_q[i])
        );
        assign lane_part[i] = lane_q[i].part;
    end

    // index merge
    rsed_merge u_merge (
        .clk    (clk),
        .ctl    (merge_ctl),
        .part   (lane_part),
        .weight (weight_reg),
        .base   (base_reg),
        .index  (merge_index)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= merge_index;
            out_col_reg   <= COL_W'(col_reg);
            out_done_reg  <= done_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.pixel_index = out_index_reg;
    assign results.column      = out_col_reg;
    assign results.row_done    = out_done_reg;

    // checks
    `RSED_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, (state_reg == S_QUANT) && !pixels.ready)
    `RSED_ASSERT_NEXT(a_row_end_wraps, clk, rst_n, accept && done, column_count_reg == '0)
    `RSED_ASSERT_IMP(a_no_take_while_clearing, clk, rst_n, clearing_reg, !pixels.ready)

endmodule

`default_nettype wire
